// ===== rtl/core/pm0_pkg.sv =====
// pm0 stack machine shared definitions: default sizes, opcodes, status codes
// and the request struct for the iterative multiply/divide unit
// no dependencies
package pm0_pkg;

  localparam int unsigned MEM_WORDS_DEF = 512;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned MAX_LEVEL_DEF = 15;

  // fixed field widths of the channels
  localparam int unsigned ACT_BITS     = 2;
  localparam int unsigned CODE_BITS    = 4;
  localparam int unsigned VAL_BITS     = 32;
  localparam int unsigned STAT_BITS    = 3;
  localparam int unsigned PTR_OUT_BITS = 10;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK   = 3'd0,
    ST_HALT = 3'd1,
    ST_DIVZ = 3'd2,
    ST_ADDR = 3'd3,
    ST_FULL = 3'd4
  } status_e;

  localparam logic [ACT_BITS-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_BITS-1:0] ACT_START = 2'd1;
  localparam logic [ACT_BITS-1:0] ACT_EXEC  = 2'd2;

  localparam int OP_LIT = 1;
  localparam int OP_OPR = 2;
  localparam int OP_LOD = 3;
  localparam int OP_STO = 4;
  localparam int OP_CAL = 5;
  localparam int OP_INC = 6;
  localparam int OP_JMP = 7;
  localparam int OP_JPC = 8;
  localparam int OP_SYS = 9;

  localparam int OPR_RTN = 0;
  localparam int OPR_NEG = 1;
  localparam int OPR_ADD = 2;
  localparam int OPR_SUB = 3;
  localparam int OPR_MUL = 4;
  localparam int OPR_DIV = 5;
  localparam int OPR_ODD = 6;
  localparam int OPR_MOD = 7;
  localparam int OPR_EQL = 8;
  localparam int OPR_NEQ = 9;
  localparam int OPR_LSS = 10;
  localparam int OPR_LEQ = 11;
  localparam int OPR_GTR = 12;
  localparam int OPR_GEQ = 13;

  localparam int SYS_WRITE = 1;
  localparam int SYS_READ  = 2;

  typedef struct packed {
    logic start;
    logic is_mul;
    logic is_mod;
  } md_req_t;

endpackage

// ===== rtl/core/pm0_in_if.sv =====
// input channel of the pm0 stack machine: one action beat
// depends on pm0_pkg for field widths
interface pm0_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pm0_pkg::ACT_BITS-1:0]         action;
  logic [pm0_pkg::CODE_BITS-1:0]        opcode_word;
  logic [pm0_pkg::CODE_BITS-1:0]        level_word;
  logic signed [pm0_pkg::VAL_BITS-1:0]  operand_word;
  logic signed [pm0_pkg::VAL_BITS-1:0]  read_value;

  modport source (output valid, action, opcode_word, level_word, operand_word, read_value,
                  input ready);
  modport sink (input valid, action, opcode_word, level_word, operand_word, read_value,
                output ready);
endinterface

// ===== rtl/core/pm0_out_if.sv =====
// result channel of the pm0 stack machine: status and pointers after a step
// depends on pm0_pkg for field widths
interface pm0_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [pm0_pkg::STAT_BITS-1:0]            status;
  logic                                     print_valid;
  logic signed [pm0_pkg::VAL_BITS-1:0]      print_value;
  logic                                     read_taken;
  logic [pm0_pkg::PTR_OUT_BITS-1:0]         pc_now;
  logic [pm0_pkg::PTR_OUT_BITS-1:0]         bp_now;
  logic [pm0_pkg::PTR_OUT_BITS-1:0]         sp_now;
  logic signed [pm0_pkg::PTR_OUT_BITS-1:0]  dp_now;

  modport source (output valid, status, print_valid, print_value, read_taken, pc_now, bp_now,
                  sp_now, dp_now, input ready);
  modport sink (input valid, status, print_valid, print_value, read_taken, pc_now, bp_now,
                sp_now, dp_now, output ready);
endinterface

// ===== rtl/core/pm0_stack_machine_step.sv =====
// pm0 stack machine top level: sequencer over one word memory
// depends on pm0_pkg, pm0_in_if, pm0_out_if, pm0_ram, pm0_muldiv
//
//  channel | dir | handshake       | payload
//  in_i    | in  | valid / ready   | action, opcode_word, level_word, operand_word, read_value
//  out_o   | out | valid / ready   | status, print_valid, print_value, read_taken, *_now
//
// after reset a clearing pass zeroes every memory word, with in_i.ready low
// load writes three words; start and halted/unknown steps go straight to handing off the result
// execute: fetch of three words, decode, then the memory reads and writes of the operation; each static
// link level walked adds a link read, cal adds 4 writes, mul/div/mod wait for the divider
// the memory port (one read, one write a cycle) sets the pace
// a new beat is taken while the previous result waits in the output register
module pm0_stack_machine_step #(
  parameter int unsigned MEM_WORDS = pm0_pkg::MEM_WORDS_DEF,
  parameter int unsigned WORD_BITS = pm0_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_LEVEL = pm0_pkg::MAX_LEVEL_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pm0_in_if.sink    in_i,
  pm0_out_if.source out_o
);

  localparam int unsigned AW  = $clog2(MEM_WORDS);
  localparam int unsigned PW  = $clog2(MEM_WORDS + 1);
  localparam int unsigned OW  = PW + 3;
  localparam int unsigned LVW = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL + 1) : 1;
  localparam int unsigned LIM = 2 ** (PW + 1);
  localparam logic signed [OW-1:0]        MEM_S = OW'(MEM_WORDS);
  localparam logic signed [OW-1:0]        LIM_S = OW'(LIM);
  localparam logic signed [WORD_BITS-1:0] LIM_W = WORD_BITS'(LIM);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_LOAD  = 5'd2;
  localparam logic [4:0] S_FETCH = 5'd3;
  localparam logic [4:0] S_DEC   = 5'd4;
  localparam logic [4:0] S_WALK  = 5'd5;
  localparam logic [4:0] S_WALKR = 5'd6;
  localparam logic [4:0] S_BASE  = 5'd7;
  localparam logic [4:0] S_MEMOP = 5'd8;
  localparam logic [4:0] S_LODW  = 5'd9;
  localparam logic [4:0] S_STOW  = 5'd10;
  localparam logic [4:0] S_CAL   = 5'd11;
  localparam logic [4:0] S_RTN1  = 5'd12;
  localparam logic [4:0] S_RTN2  = 5'd13;
  localparam logic [4:0] S_UN    = 5'd14;
  localparam logic [4:0] S_B1    = 5'd15;
  localparam logic [4:0] S_B2    = 5'd16;
  localparam logic [4:0] S_MD    = 5'd17;
  localparam logic [4:0] S_JPC   = 5'd18;
  localparam logic [4:0] S_SYS1  = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;

  // signed word clamped far outside any address range
  function automatic logic signed [OW-1:0] to_off(input logic [WORD_BITS-1:0] w);
    if ($signed(w) > LIM_W) begin
      return LIM_S;
    end else if ($signed(w) < -LIM_W) begin
      return -LIM_S;
    end
    return $signed(w[OW-1:0]);
  endfunction

  function automatic logic in_mem(input logic signed [OW-1:0] x);
    return !x[OW-1] && (x < MEM_S);
  endfunction

  function automatic logic ptr_ok(input logic signed [OW-1:0] x);
    return !x[OW-1] && (x <= MEM_S);
  endfunction

  function automatic logic [WORD_BITS-1:0] sx32(input logic [31:0] v);
    logic signed [63:0] t;
    t = 64'($signed(v));
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [WORD_BITS-1:0] w);
    logic signed [63:0] t;
    t = 64'($signed(w));
    return t[31:0];
  endfunction

  logic [4:0]  state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [PW:0] pc_q, pc_d;
  logic [PW-1:0] bp_q, bp_d, sp_q, sp_d, gp_q, gp_d, te_q, te_d;
  logic signed [PW:0] dp_q, dp_d;
  logic [PW-1:0] a_q, a_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic signed [OW-1:0] addr_q, addr_d, t_q, t_d;
  logic [WORD_BITS-1:0] op_q, op_d, lev_q, lev_d, mw_q, mw_d, opa_q, opa_d;
  logic [pm0_pkg::CODE_BITS-1:0] opw_q, opw_d, lvw_q, lvw_d;
  logic [31:0] opd_q, opd_d, rdv_q, rdv_d;
  logic rd_ok_q, rd_ok_d;
  pm0_pkg::status_e st_q, st_d;
  logic pv_q, pv_d, rt_q, rt_d;
  logic [31:0] pval_q, pval_d;

  logic out_valid_q, out_valid_d, out_load;
  pm0_pkg::status_e o_st_q;
  logic o_pv_q, o_rt_q;
  logic [31:0] o_pval_q;
  logic [pm0_pkg::PTR_OUT_BITS-1:0] o_pc_q, o_bp_q, o_sp_q, o_dp_q;

  logic mem_we, mem_re;
  logic signed [OW-1:0] waddr_s, raddr_s;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata, rv;

  pm0_pkg::md_req_t md_req;
  logic md_done;
  logic [WORD_BITS-1:0] md_res;

  logic dmode, ptr_set;
  logic signed [OW-1:0] sp_s, dp_s, bp_s, gp_s, top, second, pushed, m_s, v, ptr_val;
  logic [PW:0] fa;
  logic [WORD_BITS-1:0] bres;

  pm0_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_s[AW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (raddr_s[AW-1:0]),
    .rdata_o (mem_rdata)
  );

  pm0_muldiv #(.WORD_BITS(WORD_BITS)) u_md (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (opa_q),
    .b_i    (mem_rdata),
    .done_o (md_done),
    .res_o  (md_res)
  );

  assign dmode  = (bp_q == gp_q);
  assign sp_s   = $signed(OW'(sp_q));
  assign bp_s   = $signed(OW'(bp_q));
  assign gp_s   = $signed(OW'(gp_q));
  assign dp_s   = OW'(dp_q);
  assign top    = dmode ? dp_s : sp_s;
  assign second = dmode ? (dp_s - OW'(1)) : (sp_s + OW'(1));
  assign pushed = dmode ? (dp_s + OW'(1)) : (sp_s - OW'(1));
  assign m_s    = to_off(mw_q);
  assign fa     = pc_q + (PW + 1)'(cnt_q);
  assign rv     = rd_ok_q ? mem_rdata : '0;

  assign in_i.ready = (state_q == S_IDLE);

  // non-divider binary operations
  always_comb begin
    case (m_s)
      OW'(pm0_pkg::OPR_ADD): bres = opa_q + mem_rdata;
      OW'(pm0_pkg::OPR_SUB): bres = opa_q - mem_rdata;
      OW'(pm0_pkg::OPR_EQL): bres = WORD_BITS'(opa_q == mem_rdata);
      OW'(pm0_pkg::OPR_NEQ): bres = WORD_BITS'(opa_q != mem_rdata);
      OW'(pm0_pkg::OPR_LSS): bres = WORD_BITS'($signed(opa_q) < $signed(mem_rdata));
      OW'(pm0_pkg::OPR_LEQ): bres = WORD_BITS'($signed(opa_q) <= $signed(mem_rdata));
      OW'(pm0_pkg::OPR_GTR): bres = WORD_BITS'($signed(opa_q) > $signed(mem_rdata));
      default:               bres = WORD_BITS'($signed(opa_q) >= $signed(mem_rdata));
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    pc_d    = pc_q;
    bp_d    = bp_q;
    sp_d    = sp_q;
    dp_d    = dp_q;
    gp_d    = gp_q;
    te_d    = te_q;
    a_d     = a_q;
    lvl_d   = lvl_q;
    addr_d  = addr_q;
    t_d     = t_q;
    op_d    = op_q;
    lev_d   = lev_q;
    mw_d    = mw_q;
    opa_d   = opa_q;
    opw_d   = opw_q;
    lvw_d   = lvw_q;
    opd_d   = opd_q;
    rdv_d   = rdv_q;
    rd_ok_d = rd_ok_q;
    st_d    = st_q;
    pv_d    = pv_q;
    rt_d    = rt_q;
    pval_d  = pval_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr_s   = '0;
    raddr_s   = '0;
    mem_wdata = '0;
    md_req    = '0;
    ptr_set   = 1'b0;
    ptr_val   = '0;
    v         = '0;
    out_load  = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_CLR: begin
        mem_we  = 1'b1;
        waddr_s = $signed(OW'(clr_q));
        if (clr_q == AW'(MEM_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          opw_d  = in_i.opcode_word;
          lvw_d  = in_i.level_word;
          opd_d  = in_i.operand_word;
          rdv_d  = in_i.read_value;
          pv_d   = 1'b0;
          rt_d   = 1'b0;
          pval_d = '0;
          st_d   = pm0_pkg::ST_OK;
          cnt_d  = '0;
          state_d = S_DONE;
          case (in_i.action)
            pm0_pkg::ACT_LOAD: begin
              if ((OW'(te_q) + OW'(3)) <= OW'(MEM_WORDS)) begin
                state_d = S_LOAD;
              end else begin
                st_d = pm0_pkg::ST_FULL;
              end
            end
            pm0_pkg::ACT_START: begin
              pc_d = '0;
              sp_d = PW'(MEM_WORDS);
              gp_d = te_q;
              bp_d = te_q;
              dp_d = $signed({1'b0, te_q}) - (PW + 1)'(1);
            end
            pm0_pkg::ACT_EXEC: begin
              if (pc_q >= (PW + 1)'(te_q)) begin
                st_d = pm0_pkg::ST_HALT;
              end else begin
                state_d = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        mem_we  = 1'b1;
        waddr_s = gp_s - gp_s + $signed(OW'(te_q)) + $signed(OW'(cnt_q));
        case (cnt_q)
          2'd0:    mem_wdata = WORD_BITS'(opw_q);
          2'd1:    mem_wdata = WORD_BITS'(lvw_q);
          default: mem_wdata = sx32(opd_q);
        endcase
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          te_d    = te_q + PW'(3);
          state_d = S_DONE;
        end
      end
      S_FETCH: begin
        // three words per instruction, the read data arrives in the cycle after its address
        if (cnt_q != 2'd3) begin
          mem_re  = 1'b1;
          raddr_s = $signed(OW'(fa));
          rd_ok_d = fa < (PW + 1)'(MEM_WORDS);
        end
        case (cnt_q)
          2'd1:    op_d  = rv;
          2'd2:    lev_d = rv;
          2'd3:    mw_d  = rv;
          default: ;
        endcase
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        pc_d    = pc_q + (PW + 1)'(3);
        state_d = S_DONE;
        case (op_q)
          WORD_BITS'(pm0_pkg::OP_LIT): begin
            if (!in_mem(pushed)) begin
              st_d = pm0_pkg::ST_ADDR;
            end else begin
              mem_we    = 1'b1;
              waddr_s   = pushed;
              mem_wdata = mw_q;
              ptr_set   = 1'b1;
              ptr_val   = pushed;
            end
          end
          WORD_BITS'(pm0_pkg::OP_OPR): begin
            if (m_s == OW'(pm0_pkg::OPR_RTN)) begin
              if (bp_q < PW'(3) || bp_q == PW'(MEM_WORDS)) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                mem_re  = 1'b1;
                raddr_s = bp_s - OW'(2);
                state_d = S_RTN1;
              end
            end else if (m_s == OW'(pm0_pkg::OPR_NEG) || m_s == OW'(pm0_pkg::OPR_ODD)) begin
              if (!in_mem(top)) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                mem_re  = 1'b1;
                raddr_s = top;
                state_d = S_UN;
              end
            end else if (m_s >= OW'(pm0_pkg::OPR_ADD) && m_s <= OW'(pm0_pkg::OPR_GEQ)) begin
              if (!in_mem(top) || !in_mem(second)) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                mem_re  = 1'b1;
                raddr_s = second;
                state_d = S_B1;
              end
            end
          end
          WORD_BITS'(pm0_pkg::OP_LOD), WORD_BITS'(pm0_pkg::OP_STO),
          WORD_BITS'(pm0_pkg::OP_CAL): begin
            if (dmode && op_q != WORD_BITS'(pm0_pkg::OP_CAL)) begin
              addr_d  = gp_s + m_s;
              state_d = S_MEMOP;
            end else if (lev_q > WORD_BITS'(MAX_LEVEL)) begin
              st_d = pm0_pkg::ST_ADDR;
            end else begin
              a_d     = bp_q;
              lvl_d   = lev_q[LVW-1:0];
              state_d = S_WALK;
            end
          end
          WORD_BITS'(pm0_pkg::OP_INC): begin
            if (dmode) begin
              v = dp_s + m_s;
              if (v < -OW'(1) || v >= MEM_S) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                ptr_set = 1'b1;
                ptr_val = v;
              end
            end else begin
              v = sp_s - m_s;
              if (!ptr_ok(v)) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                ptr_set = 1'b1;
                ptr_val = v;
              end
            end
          end
          WORD_BITS'(pm0_pkg::OP_JMP): begin
            if (!ptr_ok(m_s)) begin
              st_d = pm0_pkg::ST_ADDR;
            end else begin
              pc_d = m_s[PW:0];
            end
          end
          WORD_BITS'(pm0_pkg::OP_JPC): begin
            if (!in_mem(top)) begin
              st_d = pm0_pkg::ST_ADDR;
            end else begin
              mem_re  = 1'b1;
              raddr_s = top;
              state_d = S_JPC;
            end
          end
          WORD_BITS'(pm0_pkg::OP_SYS): begin
            if (m_s == OW'(pm0_pkg::SYS_WRITE)) begin
              if (!in_mem(top)) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                mem_re  = 1'b1;
                raddr_s = top;
                state_d = S_SYS1;
              end
            end else if (m_s == OW'(pm0_pkg::SYS_READ)) begin
              if (!in_mem(pushed)) begin
                st_d = pm0_pkg::ST_ADDR;
              end else begin
                mem_we    = 1'b1;
                waddr_s   = pushed;
                mem_wdata = sx32(rdv_q);
                ptr_set   = 1'b1;
                ptr_val   = pushed;
                rt_d      = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        if (lvl_q == '0) begin
          state_d = S_BASE;
        end else if (a_q == '0) begin
          st_d    = pm0_pkg::ST_ADDR;
          state_d = S_DONE;
        end else begin
          mem_re  = 1'b1;
          raddr_s = $signed(OW'(a_q)) - OW'(1);
          state_d = S_WALKR;
        end
      end
      S_WALKR: begin
        v = to_off(mem_rdata);
        if (!ptr_ok(v)) begin
          st_d    = pm0_pkg::ST_ADDR;
          state_d = S_DONE;
        end else begin
          a_d     = v[PW-1:0];
          lvl_d   = lvl_q - LVW'(1);
          state_d = S_WALK;
        end
      end
      S_BASE: begin
        if (op_q == WORD_BITS'(pm0_pkg::OP_CAL)) begin
          if (sp_q < PW'(4) || !ptr_ok(m_s)) begin
            st_d    = pm0_pkg::ST_ADDR;
            state_d = S_DONE;
          end else begin
            cnt_d   = '0;
            state_d = S_CAL;
          end
        end else begin
          addr_d  = (a_q == gp_q) ? (gp_s + m_s) : ($signed(OW'(a_q)) - m_s);
          state_d = S_MEMOP;
        end
      end
      S_CAL: begin
        // frame words below sp: zero, static link, dynamic link, return address
        mem_we  = 1'b1;
        waddr_s = sp_s - OW'(1) - $signed(OW'(cnt_q));
        case (cnt_q)
          2'd0:    mem_wdata = '0;
          2'd1:    mem_wdata = WORD_BITS'(a_q);
          2'd2:    mem_wdata = WORD_BITS'(bp_q);
          default: mem_wdata = WORD_BITS'(pc_q);
        endcase
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          bp_d    = sp_q - PW'(1);
          pc_d    = m_s[PW:0];
          state_d = S_DONE;
        end
      end
      S_MEMOP: begin
        state_d = S_DONE;
        if (!in_mem(addr_q)) begin
          st_d = pm0_pkg::ST_ADDR;
        end else if (op_q == WORD_BITS'(pm0_pkg::OP_LOD)) begin
          if (!in_mem(pushed)) begin
            st_d = pm0_pkg::ST_ADDR;
          end else begin
            mem_re  = 1'b1;
            raddr_s = addr_q;
            state_d = S_LODW;
          end
        end else if (!in_mem(top)) begin
          st_d = pm0_pkg::ST_ADDR;
        end else begin
          mem_re  = 1'b1;
          raddr_s = top;
          state_d = S_STOW;
        end
      end
      S_LODW: begin
        mem_we    = 1'b1;
        waddr_s   = pushed;
        mem_wdata = mem_rdata;
        ptr_set   = 1'b1;
        ptr_val   = pushed;
        state_d   = S_DONE;
      end
      S_STOW: begin
        mem_we    = 1'b1;
        waddr_s   = addr_q;
        mem_wdata = mem_rdata;
        ptr_set   = 1'b1;
        ptr_val   = second;
        state_d   = S_DONE;
      end
      S_RTN1: begin
        mem_re  = 1'b1;
        raddr_s = bp_s - OW'(3);
        t_d     = to_off(mem_rdata);
        state_d = S_RTN2;
      end
      S_RTN2: begin
        v = to_off(mem_rdata);
        if (!ptr_ok(t_q) || !ptr_ok(v)) begin
          st_d = pm0_pkg::ST_ADDR;
        end else begin
          sp_d = bp_q + PW'(1);
          bp_d = t_q[PW-1:0];
          pc_d = v[PW:0];
        end
        state_d = S_DONE;
      end
      S_UN: begin
        mem_we  = 1'b1;
        waddr_s = top;
        if (m_s == OW'(pm0_pkg::OPR_NEG)) begin
          mem_wdata = ~mem_rdata + WORD_BITS'(1);
        end else if (mem_rdata[0]) begin
          // odd keeps the sign of a negative value
          mem_wdata = mem_rdata[WORD_BITS-1] ? '1 : WORD_BITS'(1);
        end
        state_d = S_DONE;
      end
      S_B1: begin
        mem_re  = 1'b1;
        raddr_s = top;
        opa_d   = mem_rdata;
        state_d = S_B2;
      end
      S_B2: begin
        if (m_s == OW'(pm0_pkg::OPR_MUL) || m_s == OW'(pm0_pkg::OPR_DIV)
            || m_s == OW'(pm0_pkg::OPR_MOD)) begin
          if (m_s != OW'(pm0_pkg::OPR_MUL) && mem_rdata == '0) begin
            st_d    = pm0_pkg::ST_DIVZ;
            state_d = S_DONE;
          end else begin
            md_req.start  = 1'b1;
            md_req.is_mul = (m_s == OW'(pm0_pkg::OPR_MUL));
            md_req.is_mod = (m_s == OW'(pm0_pkg::OPR_MOD));
            state_d       = S_MD;
          end
        end else begin
          mem_we    = 1'b1;
          waddr_s   = second;
          mem_wdata = bres;
          ptr_set   = 1'b1;
          ptr_val   = second;
          state_d   = S_DONE;
        end
      end
      S_MD: begin
        if (md_done) begin
          mem_we    = 1'b1;
          waddr_s   = second;
          mem_wdata = md_res;
          ptr_set   = 1'b1;
          ptr_val   = second;
          state_d   = S_DONE;
        end
      end
      S_JPC: begin
        state_d = S_DONE;
        if (mem_rdata == '0 && !ptr_ok(m_s)) begin
          st_d = pm0_pkg::ST_ADDR;
        end else begin
          if (mem_rdata == '0) begin
            pc_d = m_s[PW:0];
          end
          ptr_set = 1'b1;
          ptr_val = second;
        end
      end
      S_SYS1: begin
        pv_d    = 1'b1;
        pval_d  = to32(mem_rdata);
        ptr_set = 1'b1;
        ptr_val = second;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (ptr_set) begin
      if (dmode) begin
        dp_d = ptr_val[PW:0];
      end else begin
        sp_d = ptr_val[PW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cnt_q       <= '0;
      pc_q        <= '0;
      bp_q        <= '0;
      sp_q        <= PW'(MEM_WORDS);
      dp_q        <= -(PW + 1)'(1);
      gp_q        <= '0;
      te_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pc_q        <= pc_d;
      bp_q        <= bp_d;
      sp_q        <= sp_d;
      dp_q        <= dp_d;
      gp_q        <= gp_d;
      te_q        <= te_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    lvl_q   <= lvl_d;
    addr_q  <= addr_d;
    t_q     <= t_d;
    op_q    <= op_d;
    lev_q   <= lev_d;
    mw_q    <= mw_d;
    opa_q   <= opa_d;
    opw_q   <= opw_d;
    lvw_q   <= lvw_d;
    opd_q   <= opd_d;
    rdv_q   <= rdv_d;
    rd_ok_q <= rd_ok_d;
    st_q    <= st_d;
    pv_q    <= pv_d;
    rt_q    <= rt_d;
    pval_q  <= pval_d;
    if (out_load) begin
      o_st_q   <= st_q;
      o_pv_q   <= pv_q;
      o_rt_q   <= rt_q;
      o_pval_q <= pval_q;
      o_pc_q   <= pm0_pkg::PTR_OUT_BITS'(pc_q);
      o_bp_q   <= pm0_pkg::PTR_OUT_BITS'(bp_q);
      o_sp_q   <= pm0_pkg::PTR_OUT_BITS'(sp_q);
      o_dp_q   <= pm0_pkg::PTR_OUT_BITS'(dp_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = o_st_q;
  assign out_o.print_valid = o_pv_q;
  assign out_o.print_value = o_pval_q;
  assign out_o.read_taken  = o_rt_q;
  assign out_o.pc_now      = o_pc_q;
  assign out_o.bp_now      = o_bp_q;
  assign out_o.sp_now      = o_sp_q;
  assign out_o.dp_now      = o_dp_q;

  // the sequencer never reads an entry in the cycle it writes it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && waddr_s == raddr_s))
    else $error("read and write of the same entry in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q <= PW'(MEM_WORDS)) && (bp_q <= PW'(MEM_WORDS)) && (dp_q < $signed({1'b0, PW'(MEM_WORDS)})))
    else $error("pointer left its range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == S_MD))
    else $error("divider finished outside its wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_o.ready) |=> (state_q == S_DONE))
    else $error("result dropped while output register full");

endmodule

// ===== rtl/core/pm0_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module pm0_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/core/pm0_muldiv.sv =====
// iterative multiply and signed divide/modulo, one bit per cycle
// depends on pm0_pkg for md_req_t
module pm0_muldiv #(
  parameter int unsigned WORD_BITS = pm0_pkg::WORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pm0_pkg::md_req_t      req_i,
  input  logic [WORD_BITS-1:0]  a_i,
  input  logic [WORD_BITS-1:0]  b_i,
  output logic                  done_o,
  output logic [WORD_BITS-1:0]  res_o
);

  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  logic                 busy_q, busy_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 mul_q, mul_d, mod_q, mod_d, neg_q, neg_d;
  logic [WORD_BITS-1:0] x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [WORD_BITS:0]   trial;

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
  endfunction

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mul_d  = mul_q;
    mod_d  = mod_q;
    neg_d  = neg_q;
    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    trial  = {acc_q, y_q[WORD_BITS-1]} - {1'b0, x_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WORD_BITS);
      mul_d  = req_i.is_mul;
      mod_d  = req_i.is_mod;
      acc_d  = '0;
      if (req_i.is_mul) begin
        x_d   = a_i;
        y_d   = b_i;
        neg_d = 1'b0;
      end else begin
        x_d   = mag(b_i);
        y_d   = mag(a_i);
        neg_d = req_i.is_mod ? a_i[WORD_BITS-1] : (a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1]);
      end
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_d = cnt_q - CW'(1);
        if (mul_q) begin
          if (y_q[0]) begin
            acc_d = acc_q + x_q;
          end
          x_d = {x_q[WORD_BITS-2:0], 1'b0};
          y_d = {1'b0, y_q[WORD_BITS-1:1]};
        end else if (!trial[WORD_BITS]) begin
          acc_d = trial[WORD_BITS-1:0];
          y_d   = {y_q[WORD_BITS-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[WORD_BITS-2:0], y_q[WORD_BITS-1]};
          y_d   = {y_q[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  assign done_o = busy_q && (cnt_q == '0);

  always_comb begin
    if (mul_q) begin
      res_o = acc_q;
    end else if (mod_q) begin
      res_o = neg_q ? (~acc_q + WORD_BITS'(1)) : acc_q;
    end else begin
      res_o = neg_q ? (~y_q + WORD_BITS'(1)) : y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_d;
    mod_q <= mod_d;
    neg_q <= neg_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

endmodule
